// ===== src/grc_pkg.sv =====
// Shared types and codes of the grid ray caster.
package grc_pkg;

  // Opcode of an input word
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_VIEW_HEIGHT   = 3'd0;
  localparam logic [2:0] CFG_TEXTURE_WIDTH = 3'd1;
  localparam logic [2:0] CFG_ACTIVE_ROWS   = 3'd2;
  localparam logic [2:0] CFG_ACTIVE_COLS   = 3'd3;

  // Command kinds seen by the back end
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_DROP  = 2'd1;
  localparam logic [1:0] KIND_CAST  = 2'd2;

  // Width of an active grid size (values up to 127)
  localparam int DIM_W = 7;

  typedef struct packed {
    logic               opcode;
    logic [3:0]         tile_row;
    logic [3:0]         tile_col;
    logic [3:0]         tile_value;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic signed [15:0] ray_dx;
    logic signed [15:0] ray_dy;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  hit_tile;
    logic        hit_y_side;
    logic [15:0] perp_distance;
    logic [9:0]  draw_start;
    logic [9:0]  draw_end;
    logic [7:0]  texture_column;
    logic        escaped;
  } out_word_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic [1:0] kind;
    in_word_t   word;
  } cmd_t;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [10:0]      h;
    logic [8:0]       w;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } cfg_t;

  // Back end status toward the front
  typedef struct packed {
    logic clearing;
  } stat_t;

endpackage

// ===== src/grid_raycast_wall_column.sv =====
// Top level of the grid ray caster for one wall column.
//
// Input channel: in_push / in_full, one in_word per accepted word. Opcode
// write stores one tile (nonzero is a wall); opcode cast walks a ray from
// pos_x/pos_y along ray_dx/ray_dy until it enters a wall or leaves the grid.
// Result channel: out_empty / out_pop, one out_word per cast, none per write.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// view_height, texture_width, active_rows, active_cols; write only when idle.
// Words wait in a four-deep command queue; the back end runs one at a time.
// A write goes straight to the tile store. A cast takes a step and then a
// tile check with the next products for each cell crossed, a division for
// the distance (none when the step component is zero) and up to two
// divisions for the wall rows (a division that saturates ends right after
// its start), plus setup, texture and output; its run is set by the step
// loop and the shared bit-serial divider. A start outside the grid goes
// straight to output; other escapes finish after the walk.
// After reset the tile store is cleared cell by cell, during which in_full
// is high; registers take 480, 64, 12, 16.
// Results wait in a two-deep output queue; when the receiver stalls the
// back end holds its finished result and the command queue fills up.
module grid_raycast_wall_column #(
  parameter int MAX_ROWS      = 16,
  parameter int MAX_COLS      = 16,
  parameter int POS_FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  grc_pkg::in_word_t  in_word,
  output logic               in_full,
  input  logic               out_pop,
  output grc_pkg::out_word_t out_word,
  output logic               out_empty,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [10:0]        cfg_data
);
  import grc_pkg::*;

  logic [10:0] view_height_r, view_height_nxt;
  logic [8:0]  texture_width_r, texture_width_nxt;
  logic [4:0]  active_rows_r, active_rows_nxt;
  logic [4:0]  active_cols_r, active_cols_nxt;

  cfg_t      cfg;
  stat_t     stat;
  cmd_t      cmd;
  logic      cmd_empty, cmd_pop;
  logic      res_push, res_full;
  out_word_t res_word;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_comb begin
    view_height_nxt   = view_height_r;
    texture_width_nxt = texture_width_r;
    active_rows_nxt   = active_rows_r;
    active_cols_nxt   = active_cols_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_VIEW_HEIGHT:   view_height_nxt   = cfg_data;
        CFG_TEXTURE_WIDTH: texture_width_nxt = cfg_data[8:0];
        CFG_ACTIVE_ROWS:   active_rows_nxt   = cfg_data[4:0];
        CFG_ACTIVE_COLS:   active_cols_nxt   = cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_height_r   <= 11'd480;
      texture_width_r <= 9'd64;
      active_rows_r   <= 5'd12;
      active_cols_r   <= 5'd16;
    end else begin
      view_height_r   <= view_height_nxt;
      texture_width_r <= texture_width_nxt;
      active_rows_r   <= active_rows_nxt;
      active_cols_r   <= active_cols_nxt;
    end
  end

  // effective settings: clamp to legal ranges and to the store size
  always_comb begin
    cfg.h    = (view_height_r < 11'd2) ? 11'd2 :
               ((view_height_r > 11'd1024) ? 11'd1024 : view_height_r);
    cfg.w    = (texture_width_r < 9'd1) ? 9'd1 :
               ((texture_width_r > 9'd256) ? 9'd256 : texture_width_r);
    cfg.rows = (int'(active_rows_r) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : DIM_W'(active_rows_r);
    cfg.cols = (int'(active_cols_r) > MAX_COLS) ? DIM_W'(MAX_COLS) : DIM_W'(active_cols_r);
  end

  grc_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_word   (in_word),
    .in_full   (in_full),
    .stat      (stat),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  grc_back #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_COLS      (MAX_COLS),
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .stat      (stat),
    .out_push  (res_push),
    .out_word  (res_word),
    .out_full  (res_full)
  );

  grc_fifo #(.W($bits(out_word_t)), .DEPTH(2)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_word),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_word),
    .empty (out_empty)
  );

endmodule

// ===== src/grc_ram.sv =====
// Generic single write port RAM with registered read.
module grc_ram #(
  parameter int W     = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/grc_fifo.sv =====
// Small register queue with count, used between front, back and output.
module grc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== src/grc_front.sv =====
// Front end: accepts input words, classifies them and queues them for the back end.
module grc_front #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  grc_pkg::in_word_t in_word,
  output logic              in_full,
  input  grc_pkg::stat_t    stat,
  input  logic              cmd_pop,
  output grc_pkg::cmd_t     cmd,
  output logic              cmd_empty
);
  import grc_pkg::*;

  cmd_t cmd_in;
  logic q_full;
  logic push_ok;

  // classify: cast, in-range write, or write outside the store
  always_comb begin
    cmd_in.word = in_word;
    if (in_word.opcode == OP_CAST) begin
      cmd_in.kind = KIND_CAST;
    end else if ((int'(in_word.tile_row) < MAX_ROWS) &&
                 (int'(in_word.tile_col) < MAX_COLS)) begin
      cmd_in.kind = KIND_WRITE;
    end else begin
      cmd_in.kind = KIND_DROP;
    end
  end

  assign in_full = q_full || stat.clearing;
  assign push_ok = in_push && !in_full;

  grc_fifo #(.W($bits(cmd_t)), .DEPTH(4)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push_ok),
    .din   (cmd_in),
    .full  (q_full),
    .pop   (cmd_pop),
    .dout  (cmd),
    .empty (cmd_empty)
  );

endmodule

// ===== src/grc_div.sv =====
// Restoring divider, one quotient bit per cycle, saturating 16-bit quotient.
module grc_div #(
  parameter int NUMW = 32,
  parameter int DENW = 17
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic            done,
  output logic [15:0]     quo,
  output logic            sat
);

  localparam int QW  = 16;
  localparam int CNW = $clog2(QW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNW-1:0]  cnt_r, cnt_nxt;
  logic [DENW-1:0] rem_r, rem_nxt;
  logic [DENW-1:0] den_r, den_nxt;
  logic [QW-1:0]   lo_r, lo_nxt;
  logic [QW-1:0]   quo_r, quo_nxt;
  logic            sat_r, sat_nxt;
  logic [NUMW-1:0] hi;
  logic [DENW:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    lo_nxt   = lo_r;
    quo_nxt  = quo_r;
    sat_nxt  = sat_r;
    hi       = num >> QW;
    trial    = {rem_r, lo_r[QW-1]};
    if (start && !busy_r) begin
      // quotient beyond 16 bits saturates at once
      den_nxt = den;
      quo_nxt = '0;
      lo_nxt  = num[QW-1:0];
      if (hi >= NUMW'(den)) begin
        sat_nxt  = 1'b1;
        done_nxt = 1'b1;
      end else begin
        sat_nxt  = 1'b0;
        rem_nxt  = DENW'(hi);
        cnt_nxt  = CNW'(QW);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      // one restoring step
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DENW'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DENW-1:0];
        quo_nxt = {quo_r[QW-2:0], 1'b0};
      end
      lo_nxt  = {lo_r[QW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    lo_r  <= lo_nxt;
    quo_r <= quo_nxt;
    sat_r <= sat_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign sat  = sat_r;

endmodule

// ===== src/grc_back.sv =====
// Back end: tile store, DDA walk, distance, wall rows and texture column.
module grc_back #(
  parameter int MAX_ROWS      = 16,
  parameter int MAX_COLS      = 16,
  parameter int POS_FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  grc_pkg::cfg_t      cfg,
  input  grc_pkg::cmd_t      cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  output grc_pkg::stat_t     stat,
  output logic               out_push,
  output grc_pkg::out_word_t out_word,
  input  logic               out_full
);
  import grc_pkg::*;

  localparam int F     = POS_FRAC_BITS;
  localparam int DS    = 24 - F;
  localparam int MAXD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int NW    = F + $clog2(MAXD + 2);
  localparam int CXW   = $clog2(MAX_COLS + 1);
  localparam int CYW   = $clog2(MAX_ROWS + 1);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = NW + 16;
  localparam int DIVW  = (NW + DS > 28) ? NW + DS : 28;
  localparam int MW    = 32;
  localparam logic [NW-1:0] ONE = NW'(1) << F;

  // sequencer states
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_STEP = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_DIVD = 4'd5;
  localparam logic [3:0] S_WDD  = 4'd6;
  localparam logic [3:0] S_H1   = 4'd7;
  localparam logic [3:0] S_H2   = 4'd8;
  localparam logic [3:0] S_WB   = 4'd9;
  localparam logic [3:0] S_WT   = 4'd10;
  localparam logic [3:0] S_T1   = 4'd11;
  localparam logic [3:0] S_T2   = 4'd12;
  localparam logic [3:0] S_T3   = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  typedef struct packed {
    logic [15:0]    px;
    logic [15:0]    py;
    logic [15:0]    adx;
    logic [15:0]    ady;
    logic           negx;
    logic           negy;
    logic [CXW-1:0] cx;
    logic [CYW-1:0] cy;
    logic [NW-1:0]  nx;
    logic [NW-1:0]  ny;
    logic [NW-1:0]  prev;
    logic           yside;
    logic [3:0]     tile;
    logic [15:0]    pq;
    logic [PW-1:0]  pa;
    logic [PW-1:0]  pb;
    logic [MW-1:0]  m;
    out_word_t      res;
  } ctx_t;

  logic [3:0]    st_r, st_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  ctx_t          ctx_r, ctx_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [3:0]      ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [3:0]      ram_rdata;
  logic            div_start;
  logic [DIVW-1:0] div_num;
  logic [16:0]     div_den;
  logic            div_done;
  logic [15:0]     div_quo;
  logic            div_sat;

  logic [15:0]     cxf, cyf;
  logic [F-1:0]    fx, fy;
  logic [CXW-1:0]  ncx;
  logic [CYW-1:0]  ncy;
  logic            esc;
  logic [15:0]     dmag, amag, base;
  logic            aneg;
  logic [32:0]     rsum;
  logic [F-1:0]    cf;
  logic [8:0]      col9;
  logic [10:0]     hm1;

  function automatic logic [AW-1:0] tile_addr(input int y, input int x);
    return AW'(y * MAX_COLS + x);
  endfunction

  // sequencer and datapath
  always_comb begin
    ctx_nxt   = ctx_r;
    st_nxt    = st_r;
    clr_nxt   = clr_r;
    cmd_pop   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    out_push  = 1'b0;
    cxf       = 16'(cmd.word.pos_x >> F);
    cyf       = 16'(cmd.word.pos_y >> F);
    fx        = cmd.word.pos_x[F-1:0];
    fy        = cmd.word.pos_y[F-1:0];
    ncx       = ctx_r.cx;
    ncy       = ctx_r.cy;
    esc       = 1'b0;
    dmag      = ctx_r.yside ? ctx_r.ady : ctx_r.adx;
    amag      = ctx_r.yside ? ctx_r.adx : ctx_r.ady;
    base      = ctx_r.yside ? ctx_r.px : ctx_r.py;
    aneg      = ctx_r.yside ? ctx_r.negx : ctx_r.negy;
    rsum      = 33'(ctx_r.m) + ((33'(1) << DS) - 33'(1));
    cf        = '0;
    col9      = 9'(ctx_r.m >> F);
    hm1       = cfg.h - 11'd1;

    unique case (st_r)
      S_CLR: begin
        // zero the tile store after reset
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b0;
          priority case (cmd.kind)
            KIND_WRITE: begin
              cmd_pop   = 1'b1;
              ram_we    = 1'b1;
              ram_waddr = tile_addr(int'(cmd.word.tile_row), int'(cmd.word.tile_col));
              ram_wdata = cmd.word.tile_value;
            end
            KIND_CAST: begin
              cmd_pop      = 1'b1;
              ctx_nxt.res  = '0;
              ctx_nxt.px   = cmd.word.pos_x;
              ctx_nxt.py   = cmd.word.pos_y;
              ctx_nxt.negx = cmd.word.ray_dx[15];
              ctx_nxt.negy = cmd.word.ray_dy[15];
              ctx_nxt.adx  = cmd.word.ray_dx[15] ? 16'(-cmd.word.ray_dx) : cmd.word.ray_dx;
              ctx_nxt.ady  = cmd.word.ray_dy[15] ? 16'(-cmd.word.ray_dy) : cmd.word.ray_dy;
              ctx_nxt.cx   = CXW'(cxf);
              ctx_nxt.cy   = CYW'(cyf);
              ctx_nxt.nx   = cmd.word.ray_dx[15] ? NW'(fx) : ONE - NW'(fx);
              ctx_nxt.ny   = cmd.word.ray_dy[15] ? NW'(fy) : ONE - NW'(fy);
              if ((cxf >= 16'(cfg.cols)) || (cyf >= 16'(cfg.rows))) begin
                ctx_nxt.res.escaped = 1'b1;
                st_nxt              = S_OUT;
              end else begin
                st_nxt = S_MUL;
              end
            end
            default: begin
              // write outside the store: dropped
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      S_MUL: begin
        ctx_nxt.pa = PW'(ctx_r.nx) * PW'(ctx_r.ady);
        ctx_nxt.pb = PW'(ctx_r.ny) * PW'(ctx_r.adx);
        st_nxt     = S_STEP;
      end
      S_STEP: begin
        // take the nearer boundary; ties go to a row step
        if (ctx_r.pa < ctx_r.pb) begin
          ctx_nxt.prev  = ctx_r.nx;
          ctx_nxt.nx    = ctx_r.nx + ONE;
          ctx_nxt.yside = 1'b0;
          if (ctx_r.negx) begin
            esc = (ctx_r.cx == '0);
            ncx = ctx_r.cx - 1'b1;
          end else begin
            ncx = ctx_r.cx + 1'b1;
          end
          esc        = esc || (int'(ncx) >= int'(cfg.cols));
          ctx_nxt.cx = ncx;
        end else begin
          ctx_nxt.prev  = ctx_r.ny;
          ctx_nxt.ny    = ctx_r.ny + ONE;
          ctx_nxt.yside = 1'b1;
          if (ctx_r.negy) begin
            esc = (ctx_r.cy == '0);
            ncy = ctx_r.cy - 1'b1;
          end else begin
            ncy = ctx_r.cy + 1'b1;
          end
          esc        = esc || (int'(ncy) >= int'(cfg.rows));
          ctx_nxt.cy = ncy;
        end
        if (esc) begin
          ctx_nxt.res.escaped = 1'b1;
          st_nxt              = S_OUT;
        end else begin
          st_nxt = S_CHK;
        end
      end
      S_CHK: begin
        // tile of the entered cell; products for the next step meanwhile
        ctx_nxt.pa = PW'(ctx_r.nx) * PW'(ctx_r.ady);
        ctx_nxt.pb = PW'(ctx_r.ny) * PW'(ctx_r.adx);
        if (ram_rdata != 4'd0) begin
          ctx_nxt.tile           = ram_rdata;
          ctx_nxt.res.hit_tile   = ram_rdata;
          ctx_nxt.res.hit_y_side = ctx_r.yside;
          st_nxt                 = S_DIVD;
        end else begin
          st_nxt = S_STEP;
        end
      end
      S_DIVD: begin
        if (dmag == 16'd0) begin
          ctx_nxt.pq = 16'hFFFF;
          st_nxt     = S_H1;
        end else begin
          div_start = 1'b1;
          div_num   = DIVW'(ctx_r.prev) << DS;
          div_den   = 17'(dmag);
          st_nxt    = S_WDD;
        end
      end
      S_WDD: begin
        if (div_done) begin
          ctx_nxt.pq = div_sat ? 16'hFFFF : div_quo;
          st_nxt     = S_H1;
        end
      end
      S_H1: begin
        ctx_nxt.res.perp_distance = ctx_r.pq;
        if (ctx_r.pq == 16'd0) begin
          ctx_nxt.res.draw_start = '0;
          ctx_nxt.res.draw_end   = 10'(hm1);
          st_nxt                 = S_T1;
        end else begin
          ctx_nxt.m = MW'(cfg.h) * MW'({1'b0, ctx_r.pq} + 17'd1024);
          st_nxt    = S_H2;
        end
      end
      S_H2: begin
        div_start = 1'b1;
        div_num   = DIVW'(ctx_r.m);
        div_den   = {ctx_r.pq, 1'b0};
        ctx_nxt.m = (ctx_r.pq > 16'd1024) ?
                    MW'(cfg.h) * MW'(ctx_r.pq - 16'd1024) : '0;
        st_nxt    = S_WB;
      end
      S_WB: begin
        if (div_done) begin
          if (div_sat || (div_quo > 16'(hm1))) begin
            ctx_nxt.res.draw_end = 10'(hm1);
          end else begin
            ctx_nxt.res.draw_end = 10'(div_quo);
          end
          if (ctx_r.pq > 16'd1024) begin
            div_start = 1'b1;
            div_num   = DIVW'(ctx_r.m);
            div_den   = {ctx_r.pq, 1'b0};
            st_nxt    = S_WT;
          end else begin
            ctx_nxt.res.draw_start = '0;
            st_nxt                 = S_T1;
          end
        end
      end
      S_WT: begin
        if (div_done) begin
          ctx_nxt.res.draw_start = 10'(div_quo);
          st_nxt                 = S_T1;
        end
      end
      S_T1: begin
        if (ctx_r.tile > 4'd1) begin
          ctx_nxt.m = MW'(ctx_r.pq) * MW'(amag);
          st_nxt    = S_T2;
        end else begin
          ctx_nxt.res.texture_column = '0;
          st_nxt                     = S_OUT;
        end
      end
      S_T2: begin
        // fraction of the hit point along the wall
        if (dmag == 16'd0) begin
          cf = base[F-1:0];
        end else if (aneg) begin
          cf = base[F-1:0] - F'(rsum >> DS);
        end else begin
          cf = base[F-1:0] + F'(ctx_r.m >> DS);
        end
        ctx_nxt.m = MW'(cf) * MW'(cfg.w);
        st_nxt    = S_T3;
      end
      S_T3: begin
        if ((!ctx_r.yside && !ctx_r.negx && (ctx_r.adx != 16'd0)) ||
            (ctx_r.yside && ctx_r.negy)) begin
          col9 = cfg.w - col9 - 9'd1;
        end
        ctx_nxt.res.texture_column = col9[7:0];
        st_nxt                     = S_OUT;
      end
      S_OUT: begin
        if (!out_full) begin
          out_push = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
    ram_raddr = tile_addr(int'(ctx_nxt.cy), int'(ctx_nxt.cx));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_CLR;
      clr_r <= '0;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctx_r <= ctx_nxt;
  end

  assign stat.clearing = (st_r == S_CLR);
  assign out_word      = ctx_r.res;

  grc_ram #(.W(4), .DEPTH(DEPTH)) u_tiles (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  grc_div #(.NUMW(DIVW), .DENW(17)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .sat   (div_sat)
  );

  // a tile is only checked inside the active grid
  a_chk_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CHK) |-> ((int'(ctx_r.cx) < int'(cfg.cols)) &&
                         (int'(ctx_r.cy) < int'(cfg.rows))))
    else $error("walk checks a cell outside the active grid");

  // nothing is taken or delivered during the clearing pass
  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLR) |-> (!cmd_pop && !out_push))
    else $error("word moved during clearing pass");

  // a delivered result returns the sequencer to idle
  a_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |=> (st_r == S_IDLE))
    else $error("sequencer not idle after result");

  // divider finishes only while the sequencer waits on it
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> ((st_r == S_WDD) || (st_r == S_WB) || (st_r == S_WT)))
    else $error("divider result not awaited");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the grid ray caster for one wall column.
`timescale 1ns / 100ps

module tb;
  import grc_pkg::*;

  localparam int ONE_POS    = 4096;
  localparam int FRAC_MASK  = 4095;
  localparam int MAP_CELLS  = 16;
  localparam int SETTLE     = 400;
  localparam int HOLD_OFF   = 1500;
  localparam int RAND_ITEMS = 225;
  localparam int NUM_PHASES = 8;
  localparam int CYCLE_CAP  = 3000000;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t r;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  in_word_t  in_word = '0;
  logic      in_full;
  logic      out_pop = 1'b0;
  out_word_t out_word;
  logic      out_empty;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  // Shadow copy of the block's map and registers
  logic [3:0]  tile_map [MAP_CELLS*MAP_CELLS];
  logic [10:0] reg_vh;
  logic [8:0]  reg_tw;
  logic [4:0]  reg_rows;
  logic [4:0]  reg_cols;

  out_word_t pending_hits [$];
  stim_row_t stim_rows [$];
  int        errors = 0;
  int        cycles = 0;

  grid_raycast_wall_column i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_word(in_word), .in_full(in_full),
    .out_pop(out_pop), .out_word(out_word), .out_empty(out_empty),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("grid_raycast_wall_column: mismatch");
      $finish;
    end
  end

  // DDA walk of one ray over the shadow map
  function automatic out_word_t cast_ray(in_word_t w);
    out_word_t r;
    longint unsigned px, py, adx, ady, nx, ny, prev, d, pq, h, tw;
    longint unsigned top, bot, col, base, amag, m, coord, rr;
    int unsigned rows, cols, cx, cy;
    logic [15:0] ux, uy;
    bit negx, negy, ysd, aneg;
    logic [3:0] tile;
    r = '0;
    rows = reg_rows < MAP_CELLS ? reg_rows : MAP_CELLS;
    cols = reg_cols < MAP_CELLS ? reg_cols : MAP_CELLS;
    px = w.pos_x;
    py = w.pos_y;
    ux = w.ray_dx;
    uy = w.ray_dy;
    negx = ux[15];
    negy = uy[15];
    adx = negx ? 65536 - ux : ux;
    ady = negy ? 65536 - uy : uy;
    cx = px >> 12;
    cy = py >> 12;
    if (cx >= cols || cy >= rows) begin
      r.escaped = 1'b1;
      return r;
    end
    nx = negx ? (px & FRAC_MASK) : ONE_POS - (px & FRAC_MASK);
    ny = negy ? (py & FRAC_MASK) : ONE_POS - (py & FRAC_MASK);
    while (1'b1) begin
      // ties step along y
      if (nx * ady < ny * adx) begin
        prev = nx;
        nx += ONE_POS;
        ysd = 1'b0;
        if (negx) begin
          if (cx == 0) begin
            r.escaped = 1'b1;
            return r;
          end
          cx--;
        end else begin
          cx++;
        end
        if (cx >= cols) begin
          r.escaped = 1'b1;
          return r;
        end
      end else begin
        prev = ny;
        ny += ONE_POS;
        ysd = 1'b1;
        if (negy) begin
          if (cy == 0) begin
            r.escaped = 1'b1;
            return r;
          end
          cy--;
        end else begin
          cy++;
        end
        if (cy >= rows) begin
          r.escaped = 1'b1;
          return r;
        end
      end
      tile = tile_map[cy*MAP_CELLS + cx];
      if (tile != 0) break;
    end
    // perpendicular distance, Q6.10 saturating
    d = ysd ? ady : adx;
    if (d == 0) pq = 65535;
    else begin
      pq = (prev << 12) / d;
      if (pq > 65535) pq = 65535;
    end
    // wall rows
    h = reg_vh < 2 ? 2 : (reg_vh > 1024 ? 1024 : reg_vh);
    if (pq == 0) begin
      top = 0;
      bot = h - 1;
    end else begin
      bot = h * (pq + 1024) / (2 * pq);
      if (bot > h - 1) bot = h - 1;
      top = pq > 1024 ? h * (pq - 1024) / (2 * pq) : 0;
    end
    // texture column, flat walls stay at zero
    col = 0;
    if (tile > 1) begin
      tw = reg_tw < 1 ? 1 : (reg_tw > 256 ? 256 : reg_tw);
      base = ysd ? px : py;
      amag = ysd ? adx : ady;
      aneg = ysd ? negx : negy;
      m = pq * amag;
      if (d == 0) coord = base;
      else if (aneg) begin
        rr = (m + 4095) >> 12;
        coord = base - rr;
      end else begin
        coord = base + (m >> 12);
      end
      col = ((coord & FRAC_MASK) * tw) >> 12;
      if ((!ysd && !negx && adx != 0) || (ysd && negy)) col = tw - col - 1;
    end
    r.hit_tile       = tile;
    r.hit_y_side     = ysd;
    r.perp_distance  = pq[15:0];
    r.draw_start     = top[9:0];
    r.draw_end       = bot[9:0];
    r.texture_column = col[7:0];
    r.escaped        = 1'b0;
    return r;
  endfunction

  function automatic in_word_t mk_word(logic op, int row, int col, int val,
                                       int px, int py, int dx, int dy);
    in_word_t w;
    w.opcode     = op;
    w.tile_row   = row[3:0];
    w.tile_col   = col[3:0];
    w.tile_value = val[3:0];
    w.pos_x      = px[15:0];
    w.pos_y      = py[15:0];
    w.ray_dx     = dx[15:0];
    w.ray_dy     = dy[15:0];
    return w;
  endfunction

  function automatic logic [15:0] rand_dir();
    int k;
    int v;
    k = $urandom_range(0, 9);
    if (k < 7) v = int'($urandom_range(0, 32768)) - 16384;
    else if (k == 7) v = $urandom;
    else if (k == 8) v = 0;
    else begin
      case ($urandom_range(0, 2))
        0: v = 16384;
        1: v = -16384;
        default: v = -32768;
      endcase
    end
    return v[15:0];
  endfunction

  // Random word: mostly casts from inside the active grid
  function automatic in_word_t rand_word();
    in_word_t w;
    int rows, cols;
    w = in_word_t'({$urandom, $urandom, $urandom});
    rows = reg_rows < MAP_CELLS ? reg_rows : MAP_CELLS;
    cols = reg_cols < MAP_CELLS ? reg_cols : MAP_CELLS;
    if ($urandom_range(0, 9) < 3) begin
      w.opcode = OP_WRITE;
      w.tile_value = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(1, 15));
    end else begin
      w.opcode = OP_CAST;
      if (rows > 0 && cols > 0 && $urandom_range(0, 9) != 0) begin
        w.pos_x = {4'($urandom_range(0, cols - 1)), 12'($urandom)};
        w.pos_y = {4'($urandom_range(0, rows - 1)), 12'($urandom)};
      end
      w.ray_dx = rand_dir();
      w.ray_dy = rand_dir();
    end
    return w;
  endfunction

  // Push one word; leaves in_push high after acceptance
  task automatic send(in_word_t w, bit typed, out_word_t r);
    in_push <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_full);
    if (w.opcode == OP_WRITE) tile_map[{w.tile_row, w.tile_col}] = w.tile_value;
    else pending_hits.push_back(typed ? r : cast_ray(w));
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[10:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_VIEW_HEIGHT:   reg_vh   = val[10:0];
      CFG_TEXTURE_WIDTH: reg_tw   = val[8:0];
      CFG_ACTIVE_ROWS:   reg_rows = val[4:0];
      default:           reg_cols = val[4:0];
    endcase
  endtask

  task automatic set_regs(int vh, int tw, int rows, int cols);
    drain();
    write_reg(CFG_VIEW_HEIGHT, vh);
    write_reg(CFG_TEXTURE_WIDTH, tw);
    write_reg(CFG_ACTIVE_ROWS, rows);
    write_reg(CFG_ACTIVE_COLS, cols);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(in_word_t w, bit typed, out_word_t r);
    stim_row_t s;
    s.w = w;
    s.typed = typed;
    s.r = r;
    stim_rows.push_back(s);
  endtask

  // Field by field compare against the oldest expectation
  task automatic check_word(out_word_t got);
    out_word_t e;
    if (pending_hits.size() == 0) begin
      $error("unexpected result word %h", got);
      errors++;
      return;
    end
    e = pending_hits.pop_front();
    if (got.hit_tile !== e.hit_tile) begin
      $error("hit_tile exp %0d got %0d", e.hit_tile, got.hit_tile); errors++;
    end
    if (got.hit_y_side !== e.hit_y_side) begin
      $error("hit_y_side exp %0d got %0d", e.hit_y_side, got.hit_y_side); errors++;
    end
    if (got.perp_distance !== e.perp_distance) begin
      $error("perp_distance exp %0d got %0d", e.perp_distance, got.perp_distance);
      errors++;
    end
    if (got.draw_start !== e.draw_start) begin
      $error("draw_start exp %0d got %0d", e.draw_start, got.draw_start); errors++;
    end
    if (got.draw_end !== e.draw_end) begin
      $error("draw_end exp %0d got %0d", e.draw_end, got.draw_end); errors++;
    end
    if (got.texture_column !== e.texture_column) begin
      $error("texture_column exp %0d got %0d", e.texture_column, got.texture_column);
      errors++;
    end
    if (got.escaped !== e.escaped) begin
      $error("escaped exp %0d got %0d", e.escaped, got.escaped); errors++;
    end
  endtask

  // Result side: random stalls, two long hold-offs
  initial begin : drain_side
    int wt;
    int seen;
    bit no_stall;
    seen = 0;
    no_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (seen % 50 == 0) no_stall = $urandom_range(0, 2) == 0;
      wt = no_stall ? 0 : $urandom_range(0, 18);
      if (seen == 40 || seen == 700) wt = HOLD_OFF;
      if (wt > 0) begin
        out_pop <= 1'b0;
        repeat (wt) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      check_word(out_word);
      seen++;
    end
  end

  // Stimulus side
  initial begin : feed_side
    out_word_t esc, zero_hit, none;
    int gap;
    bit no_gap;
    for (int i = 0; i < MAP_CELLS*MAP_CELLS; i++) tile_map[i] = 4'd0;
    reg_vh = 11'd480;
    reg_tw = 9'd64;
    reg_rows = 5'd12;
    reg_cols = 5'd16;
    none = '0;
    esc = '0;
    esc.escaped = 1'b1;
    zero_hit = '0;
    zero_hit.hit_tile = 4'd1;
    zero_hit.draw_end = 10'd479;

    // directed table, register defaults
    add_row(mk_word(OP_CAST, 0, 0, 0, 0, 0, 16384, 0), 1, esc);          // empty map
    add_row(mk_word(OP_CAST, 0, 0, 0, 'h0800, 'hFFFF, 0, 16384), 1, esc); // start outside
    add_row(mk_word(OP_CAST, 0, 0, 0, 'h0800, 'h0800, -16384, 0), 1, esc); // off left edge
    add_row(mk_word(OP_WRITE, 2, 5, 1, 0, 0, 0, 0), 0, none);
    add_row(mk_word(OP_WRITE, 2, 9, 7, 'hFFFF, 'hFFFF, -1, -1), 0, none);
    add_row(mk_word(OP_WRITE, 6, 3, 9, 0, 0, 0, 0), 0, none);
    add_row(mk_word(OP_WRITE, 0, 3, 12, 0, 0, 0, 0), 0, none);
    add_row(mk_word(OP_WRITE, 15, 15, 15, 0, 0, 0, 0), 0, none);
    add_row(mk_word(OP_WRITE, 11, 0, 4, 0, 0, 0, 0), 0, none);
    add_row(mk_word(OP_WRITE, 5, 5, 0, 0, 0, 0, 0), 0, none);
    add_row(mk_word(OP_CAST, 0, 0, 0, 'h4FFF, 'h2800, 32767, 0), 1, zero_hit); // zero distance
    add_row(mk_word(OP_CAST, 0, 0, 0, 'h2800, 'h2800, 16384, 0), 0, none);
    add_row(mk_word(OP_CAST, 0, 0, 0, 'h7800, 'h2400, 16384, 4000), 0, none);
    add_row(mk_word(OP_CAST, 0, 0, 0, 'hC800, 'h2800, -16384, -3000), 0, none);
    add_row(mk_word(OP_CAST, 0, 0, 0, 'h3800, 'h1800, 1000, 16384), 0, none);
    add_row(mk_word(OP_CAST, 0, 0, 0, 'h3800, 'h4800, -500, -16384), 0, none);
    add_row(mk_word(OP_CAST, 0, 0, 0, 'h8800, 'h8800, -32768, -32768), 0, none);
    add_row(mk_word(OP_CAST, 0, 0, 0, 'h0800, 'h0800, 0, 0), 0, none);  // both zero
    add_row(mk_word(OP_CAST, 0, 0, 0, 'h1000, 'h1000, 16384, 16384), 0, none); // tie
    add_row(mk_word(OP_CAST, 0, 0, 0, 'h3FFF, 'h5FFF, 0, -16384), 0, none);
    add_row(mk_word(OP_CAST, 0, 0, 0, 'hFFFF, 'h0000, -16384, 16384), 0, none);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (stim_rows[i]) begin
      gap = $urandom_range(0, 18);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      send(stim_rows[i].w, stim_rows[i].typed, stim_rows[i].r);
    end

    // random phases, each under its own register setting
    no_gap = 1'b0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: ;
        1: set_regs(1024, 256, 16, 16);
        2: set_regs(2, 1, 1, 1);
        3: set_regs(0, 0, 31, 31);
        4: set_regs(2047, 511, 0, 5);
        default: set_regs($urandom_range(0, 2047), $urandom_range(0, 511),
                          $urandom_range(0, 31), $urandom_range(0, 31));
      endcase
      for (int n = 0; n < RAND_ITEMS; n++) begin
        if (n % 40 == 0) no_gap = $urandom_range(0, 2) == 0;
        // sender pause until all results are back
        if (n == RAND_ITEMS / 2) begin
          in_push <= 1'b0;
          while (pending_hits.size() != 0) @(posedge clk);
        end
        gap = no_gap ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
          if (n != RAND_ITEMS / 2) in_push <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        send(rand_word(), 1'b0, none);
      end
    end

    drain();
    if (errors == 0) begin
      $display("grid_raycast_wall_column: match");
    end else begin
      $display("grid_raycast_wall_column: mismatch");
    end
    $finish;
  end

endmodule
